// ===== rtl/core/rmed_pkg.sv =====
// Shared constants, types and chain commands of the running median block.
`timescale 1ns / 1ps

package rmed_pkg;

   // Store capacity and derived sizes
   localparam int MAX_SAMPLES = 1024;
   localparam int HALF_DEPTH  = (MAX_SAMPLES + 1) / 2;
   localparam int CNT_W       = $clog2(HALF_DEPTH + 1);
   localparam int TOTAL_W     = $clog2(MAX_SAMPLES + 1);
   localparam int SAMPLE_W    = 32;
   localparam int MED_W       = SAMPLE_W + 1;

   // Operation applied to every cell of a chain in the same cycle
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_POP    = 2'd2,
      OP_CLEAR  = 2'd3
   } rmed_op_type;

   // Command word broadcast to a chain and its cells
   typedef struct packed {
      rmed_op_type                 op;
      logic signed [SAMPLE_W-1:0]  value;
   } rmed_cmd_type;

endpackage

// ===== rtl/core/running_median.sv =====
// Running median over a sample stream, built from two sorted chains of cells.
//
// Usage: drive req_sample and req_start_new with start high while busy is low;
// the word is taken at that clock edge. req_start_new empties the store before
// the sample goes in. Each word gives one result: rsp_valid is high for one
// cycle with rsp_median_twice (twice the median, one fractional bit),
// rsp_sample_count and rsp_dropped. The receiver cannot stall the block.
// Sequence: after acceptance the sequencer steps through EXEC1 and FINISH,
// with EXEC2 between them when the sample forces an entry to move between
// halves and then be inserted too; the strobe is registered from FINISH.
// No new word is taken while busy; one can be taken in the same cycle as the
// strobe. The lower and upper chains each take one insert or pop per cycle,
// and the median is read from the front cells after the chains settle.
// Lower half is stored bit-inverted so both chains keep ascending order and
// the lower maximum sits in a front cell. With a full store and no new stream
// the sample is dropped and the previous median repeats.
// Reset empties both halves and returns the sequencer to idle; the cell
// contents are not cleared, only the counts.
`timescale 1ns / 1ps

module running_median
   import rmed_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [SAMPLE_W-1:0]  req_sample,
   input  logic                        req_start_new,
   output logic                        rsp_valid,
   output logic signed [MED_W-1:0]     rsp_median_twice,
   output logic [TOTAL_W-1:0]          rsp_sample_count,
   output logic                        rsp_dropped
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXEC1  = 4'b0010,
      ST_EXEC2  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic                       second_ff, second_in;
   logic                       second_lower_ff, second_lower_in;
   logic                       drop_ff, drop_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [MED_W-1:0]    median_ff, median_in;
   logic [TOTAL_W-1:0]         total_ff, total_in;
   logic                       dropped_ff, dropped_in;

   rmed_cmd_type lower_cmd, upper_cmd;
   logic signed [SAMPLE_W-1:0] lower_front, upper_front, lo_top;
   logic [CNT_W-1:0]           lower_count, upper_count;
   logic [TOTAL_W-1:0]         total;
   logic                       accept;
   logic                       full;

   assign accept = start && (state_ff == ST_IDLE);
   assign lo_top = ~lower_front;
   assign total  = TOTAL_W'(lower_count) + TOTAL_W'(upper_count);
   assign full   = total >= TOTAL_W'(MAX_SAMPLES);

   // lower half, stored inverted
   rmed_chain u_lower (
      .clock (clock),
      .reset (reset),
      .cmd   (lower_cmd),
      .front (lower_front),
      .count (lower_count)
   );

   // upper half
   rmed_chain u_upper (
      .clock (clock),
      .reset (reset),
      .cmd   (upper_cmd),
      .front (upper_front),
      .count (upper_count)
   );

   // sequencer: accept, rebalance step, optional second insert, result
   always_comb begin
      state_in        = state_ff;
      x_in            = x_ff;
      second_in       = second_ff;
      second_lower_in = second_lower_ff;
      drop_in         = drop_ff;
      lower_cmd       = '{op: OP_HOLD, value: ~x_ff};
      upper_cmd       = '{op: OP_HOLD, value: x_ff};
      rsp_valid_in    = 1'b0;
      median_in       = median_ff;
      total_in        = total_ff;
      dropped_in      = dropped_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in     = req_sample;
               state_in = ST_EXEC1;
               if (req_start_new) begin
                  lower_cmd.op = OP_CLEAR;
                  upper_cmd.op = OP_CLEAR;
               end
            end
         end
         ST_EXEC1: begin
            second_in = 1'b0;
            drop_in   = full;
            state_in  = ST_FINISH;
            if (!full) begin
               if (lower_count > upper_count) begin
                  if (lo_top > x_ff) begin
                     // lower max moves up, sample goes low next cycle
                     lower_cmd.op    = OP_POP;
                     upper_cmd       = '{op: OP_INSERT, value: lo_top};
                     second_in       = 1'b1;
                     second_lower_in = 1'b1;
                     state_in        = ST_EXEC2;
                  end else begin
                     upper_cmd.op = OP_INSERT;
                  end
               end else begin
                  if (lower_count == '0 || x_ff <= lo_top) begin
                     lower_cmd.op = OP_INSERT;
                  end else if (upper_count != '0 && x_ff > upper_front) begin
                     // upper min moves down, sample goes high next cycle
                     upper_cmd.op    = OP_POP;
                     lower_cmd       = '{op: OP_INSERT, value: ~upper_front};
                     second_in       = 1'b1;
                     second_lower_in = 1'b0;
                     state_in        = ST_EXEC2;
                  end else begin
                     lower_cmd.op = OP_INSERT;
                  end
               end
            end
         end
         ST_EXEC2: begin
            if (second_lower_ff) begin
               lower_cmd.op = OP_INSERT;
            end else begin
               upper_cmd.op = OP_INSERT;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // median from the front cells: twice the lower front, or the sum of both
            if (lower_count == '0) begin
               median_in = '0;
            end else if (lower_count > upper_count) begin
               median_in = {lo_top, 1'b0};
            end else begin
               median_in = {lo_top[SAMPLE_W-1], lo_top}
                         + {upper_front[SAMPLE_W-1], upper_front};
            end
            total_in     = total;
            dropped_in   = drop_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff            <= x_in;
      second_ff       <= second_in;
      second_lower_ff <= second_lower_in;
      drop_ff         <= drop_in;
      median_ff       <= median_in;
      total_ff        <= total_in;
      dropped_ff      <= dropped_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_twice = median_ff;
   assign rsp_sample_count = total_ff;
   assign rsp_dropped      = dropped_ff;

`ifndef SYNTH
   // a result strobe comes only after the finish step
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_FINISH))
      else $error("result strobe without finish step");

   // halves stay balanced between words
   a_balanced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |->
         (lower_count == upper_count || lower_count == upper_count + CNT_W'(1)))
      else $error("halves out of balance");

   // store never exceeds capacity
   a_capacity: assert property (@(posedge clock) disable iff (reset)
      total <= TOTAL_W'(MAX_SAMPLES))
      else $error("store over capacity");

   // second step only when a move between halves was made
   a_second_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC2) |-> (second_ff && $past(state_ff == ST_EXEC1)))
      else $error("unexpected second step");
`endif

endmodule

// ===== rtl/core/rmed_cell.sv =====
// One cell of a sorted chain: holds one entry and trades it with its neighbors.
`timescale 1ns / 1ps

module rmed_cell
   import rmed_pkg::*;
(
   input  logic                        clock,
   input  rmed_cmd_type                cmd,
   input  logic                        valid,
   input  logic signed [SAMPLE_W-1:0]  left_value,
   input  logic                        left_le,
   input  logic signed [SAMPLE_W-1:0]  right_value,
   output logic signed [SAMPLE_W-1:0]  value,
   output logic                        le
);

   logic signed [SAMPLE_W-1:0] value_ff;
   logic signed [SAMPLE_W-1:0] value_in;

   // entry sits at or before the insertion point
   assign le    = valid && (value_ff <= cmd.value);
   assign value = value_ff;

   // next entry: keep, take the new word, or shift from a neighbor
   always_comb begin
      value_in = value_ff;
      case (cmd.op)
         OP_INSERT: begin
            if (!le) begin
               value_in = left_le ? cmd.value : left_value;
            end
         end
         OP_POP: begin
            value_in = right_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== rtl/core/rmed_chain.sv =====
// Ascending chain of cells with an occupancy count; front entry is the minimum.
`timescale 1ns / 1ps

module rmed_chain
   import rmed_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  rmed_cmd_type                cmd,
   output logic signed [SAMPLE_W-1:0]  front,
   output logic [CNT_W-1:0]            count
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic signed [SAMPLE_W-1:0] cell_value [HALF_DEPTH];
   logic                       cell_le    [HALF_DEPTH];

   // row of cells, each wired to its two neighbors
   for (genvar i = 0; i < HALF_DEPTH; i++) begin : g_cell
      logic signed [SAMPLE_W-1:0] left_v;
      logic                       left_l;
      logic signed [SAMPLE_W-1:0] right_v;

      if (i == 0) begin : g_first
         assign left_v = cmd.value;
         assign left_l = 1'b1;
      end else begin : g_mid
         assign left_v = cell_value[i-1];
         assign left_l = cell_le[i-1];
      end

      if (i == HALF_DEPTH - 1) begin : g_last
         assign right_v = cell_value[i];
      end else begin : g_body
         assign right_v = cell_value[i+1];
      end

      rmed_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .valid       (count_ff > CNT_W'(i)),
         .left_value  (left_v),
         .left_le     (left_l),
         .right_value (right_v),
         .value       (cell_value[i]),
         .le          (cell_le[i])
      );
   end

   // occupancy count
   always_comb begin
      count_in = count_ff;
      case (cmd.op)
         OP_INSERT: count_in = count_ff + CNT_W'(1);
         OP_POP:    count_in = count_ff - CNT_W'(1);
         OP_CLEAR:  count_in = '0;
         default:   count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign front = cell_value[0];
   assign count = count_ff;

endmodule
